// ----- src/dstp_pkg.sv -----
// Shared types, codes and constants for the disk image sector table parser.
`default_nettype none
package dstp_pkg;

  typedef enum logic [2:0] {
    KIND_SECTOR      = 3'd0,
    KIND_SUMMARY     = 3'd1,
    KIND_SHORT_FILE  = 3'd2,
    KIND_BAD_SIG     = 3'd3,
    KIND_BAD_REV     = 3'd4,
    KIND_BAD_HDRSIZE = 3'd5
  } kind_e;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_TABLE  = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  localparam int unsigned HdrEnd    = 32'h120;
  localparam int unsigned HsizeOff  = 32'h110;
  localparam int unsigned NheadOff  = 32'h115;
  localparam int unsigned SlotBytes = 16;
  localparam int unsigned SigLen    = 13;
  localparam int unsigned EntryLen  = 11;
  localparam logic [7:0]  SlotEmpty = 8'hFF;
  localparam logic [7:0]  RevByte   = 8'h30;
  localparam logic [12:0] CountMax  = 13'd8191;

  typedef struct packed {
    kind_e        kind;
    logic [8:0]   cyl;
    logic [8:0]   head;
    logic [12:0]  record;
    logic [7:0]   size_code;
    logic [14:0]  sector_bytes;
    logic [7:0]   mfm;
    logic [7:0]   ddam;
    logic [7:0]   status;
    logic [23:0]  fdc_status;
    logic [7:0]   pda;
    logic [32:0]  data_offset;
  } result_t;

  // Expected image signature, one byte per header offset
  function automatic logic [7:0] sig_byte(input logic [3:0] idx);
    logic [7:0] r;
    unique case (idx)
      4'd0:    r = 8'h54; // T
      4'd1:    r = 8'h39; // 9
      4'd2:    r = 8'h38; // 8
      4'd3:    r = 8'h46; // F
      4'd4:    r = 8'h44; // D
      4'd5:    r = 8'h44; // D
      4'd6:    r = 8'h49; // I
      4'd7:    r = 8'h4D; // M
      4'd8:    r = 8'h41; // A
      4'd9:    r = 8'h47; // G
      4'd10:   r = 8'h45; // E
      4'd11:   r = 8'h2E; // .
      4'd12:   r = 8'h52; // R
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/disk_image_sector_table_parser.sv -----
// Top level: floppy image header check and sector table walk.
//
//  port group  | direction | handshake               | payload
//  ------------+-----------+-------------------------+-------------------------------
//  cfg         | in        | cfg_valid_i/cfg_ready_o | cfg_data_i (file length)
//  in          | in        | in_valid_i/in_stall_o   | byte_value_i
//  out         | out       | out_valid_o/out_stall_i | kind_o .. data_offset_o
//
//  One byte is taken per cycle while in_stall_o is low; a result appears in the cycle
//  after the byte that causes it. After reset every address of the track histogram RAM
//  is swept to zero with in_stall_o high; cfg writes are taken throughout.
//  The last byte of a slot may give two results; the second waits in a spare register
//  and holds in_stall_o high until it moves to the output register. A stalled output also stalls the input.
//  The histogram read is issued on slot byte 1 and written back on slot byte 15.
`default_nettype none
module disk_image_sector_table_parser #(
  parameter int unsigned TABLE_SLOTS   = 4238,
  parameter int unsigned MAX_SIZE_CODE = 7,
  parameter int unsigned KEY_BITS      = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  byte_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       kind_o,
  output logic [8:0]       cyl_o,
  output logic [8:0]       head_o,
  output logic [12:0]      record_o,
  output logic [7:0]       size_code_o,
  output logic [14:0]      sector_bytes_o,
  output logic [7:0]       mfm_o,
  output logic [7:0]       ddam_o,
  output logic [7:0]       status_o,
  output logic [23:0]      fdc_status_o,
  output logic [7:0]       pda_o,
  output logic [32:0]      data_offset_o
);
  import dstp_pkg::*;

  localparam int unsigned TableEnd = HdrEnd + TABLE_SLOTS * SlotBytes;
  localparam int unsigned OffW     = $clog2(TableEnd + SlotBytes + 2);
  localparam int unsigned HistD    = 1 << KEY_BITS;

  logic [31:0]       file_length_q;
  logic [OffW-1:0]   off_q, off_d;
  logic [1:0]        phase_q, phase_d;
  logic [31:0]       hsize_q, hsize_d;
  logic [7:0]        hcount_q, hcount_d;
  logic [7:0]        entry_q [EntryLen];
  logic [12:0]       vcount_q, vcount_d;
  logic [26:0]       run_q, run_d;
  logic [7:0]        maxc_q, maxc_d;
  logic [7:0]        maxh_q, maxh_d;
  logic [14:0]       fsize_q, fsize_d;
  logic [12:0]       mpt_q, mpt_d;
  logic [12:0]       hist_q;
  logic              rd_pend_q;
  logic [KEY_BITS:0] clr_cnt_q;
  logic              clr_busy;

  result_t           out_q, pend_q, r0, r1;
  logic              out_valid_q, pend_valid_q;
  logic              pop, accept;
  logic [1:0]        n_res;

  logic [OffW-1:0]   rel;
  logic [3:0]        pos;
  logic              fits_next;
  logic              desc_hit;
  logic [2:0]        nc;
  logic [14:0]       sz;
  logic [12:0]       hist_inc;
  logic [KEY_BITS-1:0] rd_key, wr_key;
  logic [12:0]       hist_rdata;
  logic              hist_re, hist_we;
  logic [31:0]       hsize_full;
  result_t           summ, desc;

  assign cfg_ready_o = 1'b1;
  assign clr_busy    = !clr_cnt_q[KEY_BITS];
  assign pop         = out_valid_q && !out_stall_i;
  assign in_stall_o  = clr_busy || pend_valid_q || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;

  assign rel = off_q - OffW'(HdrEnd);
  assign pos = rel[3:0];
  assign fits_next = ({1'b0, off_q} + (OffW+1)'(1) < (OffW+1)'(TableEnd)) &&
                     (33'(off_q) + 33'd17 <= {1'b0, file_length_q});

  assign nc = (entry_q[3] > 8'(MAX_SIZE_CODE)) ? 3'(MAX_SIZE_CODE) : entry_q[3][2:0];
  assign sz = 15'd128 << nc;
  assign hist_inc = (hist_q < CountMax) ? hist_q + 13'd1 : hist_q;
  assign desc_hit = accept && (phase_q == PH_TABLE) && (pos == 4'd15) &&
                    (entry_q[0] != SlotEmpty);
  assign hsize_full = {byte_value_i, hsize_q[23:0]};

  assign rd_key  = KEY_BITS'({entry_q[0], byte_value_i});
  assign wr_key  = KEY_BITS'({entry_q[0], entry_q[1]});
  assign hist_re = accept && (phase_q == PH_TABLE) && (pos == 4'd1);
  assign hist_we = clr_busy || desc_hit;

  dstp_ram #(.WIDTH(13), .DEPTH(HistD)) u_hist (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (clr_busy ? clr_cnt_q[KEY_BITS-1:0] : wr_key),
    .wdata_i (clr_busy ? 13'd0 : hist_inc),
    .re_i    (hist_re),
    .raddr_i (rd_key),
    .rdata_o (hist_rdata)
  );

  // Descriptor and running statistics
  always_comb begin
    vcount_d = vcount_q;
    run_d    = run_q;
    maxc_d   = maxc_q;
    maxh_d   = maxh_q;
    fsize_d  = fsize_q;
    mpt_d    = mpt_q;
    desc     = '0;
    desc.kind         = KIND_SECTOR;
    desc.cyl          = {1'b0, entry_q[0]};
    desc.head         = {1'b0, entry_q[1]};
    desc.record       = {5'd0, entry_q[2]};
    desc.size_code    = entry_q[3];
    desc.sector_bytes = sz;
    desc.mfm          = entry_q[4];
    desc.ddam         = entry_q[5];
    desc.status       = entry_q[6];
    desc.fdc_status   = {entry_q[9], entry_q[8], entry_q[7]};
    desc.pda          = entry_q[10];
    desc.data_offset  = 33'(hsize_q) + 33'(run_q);
    if (desc_hit) begin
      run_d = run_q + 27'(sz);
      if (vcount_q == 13'd0) fsize_d = sz;
      if (vcount_q < CountMax) vcount_d = vcount_q + 13'd1;
      if (entry_q[0] > maxc_q) maxc_d = entry_q[0];
      if (entry_q[1] > maxh_q) maxh_d = entry_q[1];
      if (hist_inc > mpt_q) mpt_d = hist_inc;
    end
    summ = '0;
    summ.kind         = KIND_SUMMARY;
    summ.cyl          = 9'(maxc_d) + 9'd1;
    summ.head         = (hcount_q != 8'd0) ? {1'b0, hcount_q} : 9'(maxh_d) + 9'd1;
    summ.record       = (mpt_d != 13'd0) ? mpt_d : 13'd8;
    summ.sector_bytes = (vcount_d != 13'd0) ? fsize_d : 15'd512;
    summ.data_offset  = 33'(vcount_d);
  end

  // Byte sequencing: header checks, then slot walk
  always_comb begin
    off_d    = off_q;
    phase_d  = phase_q;
    hsize_d  = hsize_q;
    hcount_d = hcount_q;
    n_res    = 2'd0;
    r0       = '0;
    r1       = summ;
    if (accept && phase_q != PH_DONE) begin
      off_d = off_q + OffW'(1);
      unique case (phase_q)
        PH_HEADER: begin
          if (off_q == '0 && file_length_q < HdrEnd) begin
            r0.kind = KIND_SHORT_FILE; n_res = 2'd1; phase_d = PH_DONE;
          end else if (off_q < OffW'(SigLen) && byte_value_i != sig_byte(off_q[3:0])) begin
            r0.kind = KIND_BAD_SIG; n_res = 2'd1; phase_d = PH_DONE;
          end else if (off_q == OffW'(SigLen) && byte_value_i != RevByte) begin
            r0.kind = KIND_BAD_REV; n_res = 2'd1; phase_d = PH_DONE;
          end else begin
            case (off_q)
              OffW'(HsizeOff):     hsize_d[7:0]   = byte_value_i;
              OffW'(HsizeOff + 1): hsize_d[15:8]  = byte_value_i;
              OffW'(HsizeOff + 2): hsize_d[23:16] = byte_value_i;
              OffW'(HsizeOff + 3): hsize_d[31:24] = byte_value_i;
              default: ;
            endcase
            if (off_q == OffW'(HsizeOff + 3) &&
                (hsize_full < HdrEnd || hsize_full > file_length_q)) begin
              r0.kind = KIND_BAD_HDRSIZE; n_res = 2'd1; phase_d = PH_DONE;
            end
            if (off_q == OffW'(NheadOff)) hcount_d = byte_value_i;
            if (off_q == OffW'(HdrEnd - 1)) begin
              phase_d = PH_TABLE;
              if (!fits_next) begin
                r0 = summ; n_res = 2'd1; phase_d = PH_DONE;
              end
            end
          end
        end
        PH_TABLE: begin
          if (pos == 4'd15) begin
            if (desc_hit) begin
              r0 = desc; n_res = 2'd1;
              if (!fits_next) n_res = 2'd2;
            end else if (!fits_next) begin
              r0 = summ; n_res = 2'd1;
            end
            if (!fits_next) phase_d = PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_length_q <= '0;
      off_q         <= '0;
      phase_q       <= PH_HEADER;
      hsize_q       <= '0;
      hcount_q      <= '0;
      vcount_q      <= '0;
      run_q         <= '0;
      maxc_q        <= '0;
      maxh_q        <= '0;
      fsize_q       <= '0;
      mpt_q         <= '0;
      rd_pend_q     <= 1'b0;
      clr_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
      pend_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) file_length_q <= cfg_data_i;
      if (clr_busy) clr_cnt_q <= clr_cnt_q + (KEY_BITS+1)'(1);
      off_q     <= off_d;
      phase_q   <= phase_d;
      hsize_q   <= hsize_d;
      hcount_q  <= hcount_d;
      vcount_q  <= vcount_d;
      run_q     <= run_d;
      maxc_q    <= maxc_d;
      maxh_q    <= maxh_d;
      fsize_q   <= fsize_d;
      mpt_q     <= mpt_d;
      rd_pend_q <= hist_re;
      if (accept) begin
        out_valid_q  <= (n_res != 2'd0);
        pend_valid_q <= (n_res == 2'd2);
      end else if (pend_valid_q && (!out_valid_q || pop)) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= 1'b0;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (rd_pend_q) hist_q <= hist_rdata;
    if (accept && phase_q == PH_TABLE && pos < 4'(EntryLen)) begin
      for (int i = 0; i < EntryLen; i++) begin
        if (pos == 4'(i)) entry_q[i] <= byte_value_i;
      end
    end
    if (accept) begin
      out_q  <= r0;
      pend_q <= r1;
    end else if (pend_valid_q && (!out_valid_q || pop)) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign cyl_o          = out_q.cyl;
  assign head_o         = out_q.head;
  assign record_o       = out_q.record;
  assign size_code_o    = out_q.size_code;
  assign sector_bytes_o = out_q.sector_bytes;
  assign mfm_o          = out_q.mfm;
  assign ddam_o         = out_q.ddam;
  assign status_o       = out_q.status;
  assign fdc_status_o   = out_q.fdc_status;
  assign pda_o          = out_q.pda;
  assign data_offset_o  = out_q.data_offset;

  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q) else $error("spare result without held result");

  a_done_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE |=> phase_q == PH_DONE && $stable(off_q))
    else $error("parser left done state");

  a_hist_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(hist_re && hist_we)) else $error("histogram read and write collide");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !accept) else $error("item taken during histogram clear");

endmodule
`default_nettype wire

// ----- src/dstp_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none
module dstp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire
